### hw/rtl/gb5_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and tap weight mapping for the 5x5 RGB Gaussian blur.
// No dependencies; every other file of the block imports this package.
package gb5_pkg;

  // Image and window geometry
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int WINDOW_SIZE = 5;
  localparam int STORE_LINES = WINDOW_SIZE - 1;
  localparam int CENTER_TAP  = WINDOW_SIZE / 2;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int POS_W = 11;

  // Datapath widths
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = PIX_W + COEF_W;
  localparam int ROW_SUM_W = PROD_W + $clog2(WINDOW_SIZE);
  localparam int TOTAL_W   = PROD_W + $clog2(WINDOW_SIZE * WINDOW_SIZE);

  // Configuration registers
  localparam int NUM_REGS    = 7;
  localparam int NUM_COEFF   = 6;
  localparam int CFG_WIDTH_W = 12;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W   = CFG_ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_COEFF_CORNER,
    REG_COEFF_OUTER_NEAR_CORNER,
    REG_COEFF_OUTER_MIDDLE,
    REG_COEFF_INNER_DIAGONAL,
    REG_COEFF_INNER_CROSS,
    REG_COEFF_CENTER
  } reg_idx_t;

  // Weight classes, in register order after image_width
  localparam int CLS_CORNER       = 0;
  localparam int CLS_OUTER_NEAR   = 1;
  localparam int CLS_OUTER_MIDDLE = 2;
  localparam int CLS_INNER_DIAG   = 3;
  localparam int CLS_INNER_CROSS  = 4;
  localparam int CLS_CENTER       = 5;
  localparam int CLS_W            = $clog2(NUM_COEFF);

  localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [COEF_W-1:0] COEFF_RESET [NUM_COEFF] =
    '{16'd824, 16'd1649, 16'd2061, 16'd3710, 16'd4946, 16'd6183};

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef pix_t [STORE_LINES-1:0] line_set_t;

  typedef struct packed {
    logic [PROD_W-1:0] red;
    logic [PROD_W-1:0] green;
    logic [PROD_W-1:0] blue;
  } tap_prod_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [POS_W-1:0] window_x;
    logic [POS_W-1:0] window_y;
  } out_word_t;

  // Map a window tap to its weight class by distance from the center
  function automatic int unsigned tap_class(input int unsigned r, input int unsigned c);
    int unsigned dr;
    int unsigned dc;
    int unsigned lo;
    int unsigned hi;
    int unsigned cls;
    dr  = (r > CENTER_TAP) ? r - CENTER_TAP : CENTER_TAP - r;
    dc  = (c > CENTER_TAP) ? c - CENTER_TAP : CENTER_TAP - c;
    lo  = (dr < dc) ? dr : dc;
    hi  = (dr < dc) ? dc : dr;
    cls = CLS_CENTER;
    if (hi == 2) begin
      if (lo == 2) cls = CLS_CORNER;
      else if (lo == 1) cls = CLS_OUTER_NEAR;
      else cls = CLS_OUTER_MIDDLE;
    end else if (hi == 1) begin
      if (lo == 1) cls = CLS_INNER_DIAG;
      else cls = CLS_INNER_CROSS;
    end
    return cls;
  endfunction

endpackage

### hw/rtl/gb5_line_store.sv
`timescale 1ns / 1ps
// Four-line pixel store, one packed entry per column, one read and one write a cycle.
// Depends on gb5_pkg for the pixel and line-set types.
module gb5_line_store (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [gb5_pkg::COL_W-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [gb5_pkg::COL_W-1:0] wr_addr,
  input  gb5_pkg::pix_t            pix_in,
  output gb5_pkg::line_set_t       lines
);
  import gb5_pkg::*;

  line_set_t mem [MAX_WIDTH];
  line_set_t rd_q_r;
  line_set_t wr_data;

  // Push the new pixel in as line 0 and age the other lines by one
  assign wr_data = {rd_q_r[STORE_LINES-2:0], pix_in};

  // Read the column's lines; hold them until the next read.
  // Forward the column being written when the same column is read at once
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_q_r <= wr_data;
      end else begin
        rd_q_r <= mem[rd_addr];
      end
    end
  end

  // Write back the aged column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign lines = rd_q_r;

endmodule

### hw/rtl/gb5_tap_cell.sv
`timescale 1ns / 1ps
// One window tap: holds a pixel, hands it to the left neighbor, weights each channel.
// Depends on gb5_pkg for the pixel and product types.
module gb5_tap_cell (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic                        mult_en,
  input  gb5_pkg::pix_t               pix_in,
  input  logic [gb5_pkg::COEF_W-1:0]  weight,
  output gb5_pkg::pix_t               pix_out,
  output gb5_pkg::tap_prod_t          prod
);
  import gb5_pkg::*;

  pix_t      pix_r;
  tap_prod_t prod_r;

  // Take the pixel from the right neighbor
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r <= pix_in;
    end
  end

  // Weight the held pixel on each channel
  always_ff @(posedge clk) begin
    if (mult_en) begin
      prod_r.red   <= PROD_W'(pix_r.red) * PROD_W'(weight);
      prod_r.green <= PROD_W'(pix_r.green) * PROD_W'(weight);
      prod_r.blue  <= PROD_W'(pix_r.blue) * PROD_W'(weight);
    end
  end

  assign pix_out = pix_r;
  assign prod    = prod_r;

endmodule

### hw/rtl/gb5_sum_tree.sv
`timescale 1ns / 1ps
// Two-stage registered adder tree over the 25 weighted taps of one channel.
// Depends on gb5_pkg for window size and sum widths.
module gb5_sum_tree (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gb5_pkg::PROD_W-1:0]    prod_in [gb5_pkg::WINDOW_SIZE][gb5_pkg::WINDOW_SIZE],
  output logic [gb5_pkg::TOTAL_W-1:0]   total
);
  import gb5_pkg::*;

  logic [ROW_SUM_W-1:0] row_sum_nxt [WINDOW_SIZE];
  logic [ROW_SUM_W-1:0] row_sum_r   [WINDOW_SIZE];
  logic [TOTAL_W-1:0]   total_nxt;
  logic [TOTAL_W-1:0]   total_r;

  // Sum each window row
  always_comb begin
    for (int r = 0; r < WINDOW_SIZE; r++) begin
      row_sum_nxt[r] = '0;
      for (int c = 0; c < WINDOW_SIZE; c++) begin
        row_sum_nxt[r] = row_sum_nxt[r] + ROW_SUM_W'(prod_in[r][c]);
      end
    end
  end

  // Sum the row totals
  always_comb begin
    total_nxt = '0;
    for (int r = 0; r < WINDOW_SIZE; r++) begin
      total_nxt = total_nxt + TOTAL_W'(row_sum_r[r]);
    end
  end

  // Advance both tree stages with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      row_sum_r <= row_sum_nxt;
      total_r   <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

### hw/rtl/gaussian_blur_5x5_rgb_unit.sv
`timescale 1ns / 1ps
// Streaming 5x5 Gaussian blur on 24-bit RGB pixels in raster order, one pixel per clock.
// Depends on gb5_pkg, gb5_line_store, gb5_tap_cell and gb5_sum_tree.
//
// Pixels enter at one per clock and a registered result follows the pixel that
// completes its window (the bottom-right tap), tagged with the window's top-left
// column and row. The rate is set by the single read and single write port of the
// column-packed line store, which both serve every pixel; the 5x5 row of tap cells
// shifts one column per pixel and multiplies in parallel, and a two-stage adder tree
// per channel finishes the sum. The input is stalled only while a result waits in
// the output register and another result has reached the last pipeline stage;
// pixels that produce no result keep flowing past a waiting result. The line store
// needs no clearing after reset: each line is written in the frame before a result
// uses it. Configuration: image_width at 0x00, then the six Q0.16 weights (corner,
// outer near corner, outer middle, inner diagonal, inner cross, center) at 0x04..0x18;
// write them only while the stream is idle.
module gaussian_blur_5x5_rgb_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gb5_pkg::in_word_t                 in_data,
  // filtered output
  output logic                              out_valid,
  input  logic                              out_stall,
  output gb5_pkg::out_word_t                out_data,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gb5_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gb5_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import gb5_pkg::*;

  localparam int CMP_W   = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
  localparam int DEPTH   = 4;
  localparam int LAST    = DEPTH - 1;
  localparam int MARGIN  = WINDOW_SIZE - 1;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pos_t;

  // ---------------- configuration registers ----------------
  logic [CFG_WIDTH_W-1:0] width_r;
  logic [COEF_W-1:0]      coeff_r [NUM_COEFF];
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  // Write a register at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      coeff_r <= COEFF_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:             width_r <= pwdata[CFG_WIDTH_W-1:0];
        REG_COEFF_CORNER:            coeff_r[CLS_CORNER] <= pwdata[COEF_W-1:0];
        REG_COEFF_OUTER_NEAR_CORNER: coeff_r[CLS_OUTER_NEAR] <= pwdata[COEF_W-1:0];
        REG_COEFF_OUTER_MIDDLE:      coeff_r[CLS_OUTER_MIDDLE] <= pwdata[COEF_W-1:0];
        REG_COEFF_INNER_DIAGONAL:    coeff_r[CLS_INNER_DIAG] <= pwdata[COEF_W-1:0];
        REG_COEFF_INNER_CROSS:       coeff_r[CLS_INNER_CROSS] <= pwdata[COEF_W-1:0];
        REG_COEFF_CENTER:            coeff_r[CLS_CENTER] <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back a register
  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:             prdata = CFG_DATA_W'(width_r);
      REG_COEFF_CORNER:            prdata = CFG_DATA_W'(coeff_r[CLS_CORNER]);
      REG_COEFF_OUTER_NEAR_CORNER: prdata = CFG_DATA_W'(coeff_r[CLS_OUTER_NEAR]);
      REG_COEFF_OUTER_MIDDLE:      prdata = CFG_DATA_W'(coeff_r[CLS_OUTER_MIDDLE]);
      REG_COEFF_INNER_DIAGONAL:    prdata = CFG_DATA_W'(coeff_r[CLS_INNER_DIAG]);
      REG_COEFF_INNER_CROSS:       prdata = CFG_DATA_W'(coeff_r[CLS_INNER_CROSS]);
      REG_COEFF_CENTER:            prdata = CFG_DATA_W'(coeff_r[CLS_CENTER]);
      default:                     prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic      adv;
  logic      acc;
  logic      out_valid_r;
  out_word_t out_data_r;
  logic [DEPTH-1:0] prod_pipe_r;
  pos_t             pos_pipe_r [DEPTH];

  // Freeze only when a result must enter a full, stalled output register
  assign adv      = !(out_valid_r && out_stall && prod_pipe_r[LAST]);
  assign acc      = in_valid && adv;
  assign in_stall = !adv;

  // ---------------- position counters ----------------
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_start;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic             produce;

  // Clamp the line width into the supported range
  always_comb begin
    width_eff = CMP_W'(width_r);
    if (width_eff < CMP_W'(WINDOW_SIZE)) width_eff = CMP_W'(WINDOW_SIZE);
    if (width_eff > CMP_W'(MAX_WIDTH)) width_eff = CMP_W'(MAX_WIDTH);
  end

  // Place the current pixel and step the counters
  always_comb begin
    col_start = in_data.frame_start ? '0 : CMP_W'(col_r);
    row_cur   = in_data.frame_start ? '0 : row_r;
    col_cur   = (col_start >= width_eff) ? '0 : col_start[COL_W-1:0];
    produce   = (col_cur >= COL_W'(MARGIN)) && (row_cur >= ROW_W'(MARGIN));
    if (CMP_W'(col_cur) + CMP_W'(1) >= width_eff) begin
      col_nxt = '0;
      row_nxt = (row_cur < ROW_W'(MAX_HEIGHT - 1)) ? row_cur + ROW_W'(1) : row_cur;
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: line store read ----------------
  logic             s1_valid_r;
  logic             s1_prod_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  pos_t             s1_pos_r;
  line_set_t        lines;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_prod_r  <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
      s1_prod_r  <= acc && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r   <= '{red: in_data.red_in, green: in_data.green_in, blue: in_data.blue_in};
      s1_col_r   <= col_cur;
      s1_pos_r.x <= POS_W'(col_cur - COL_W'(MARGIN));
      s1_pos_r.y <= POS_W'(row_cur - ROW_W'(MARGIN));
    end
  end

  gb5_line_store u_line_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_cur),
    .wr_en   (adv && s1_valid_r),
    .wr_addr (s1_col_r),
    .pix_in  (s1_pix_r),
    .lines   (lines)
  );

  // ---------------- window: row of tap cells ----------------
  pix_t      col_pix  [WINDOW_SIZE];
  pix_t      cell_pix [WINDOW_SIZE][WINDOW_SIZE];
  tap_prod_t cell_prod [WINDOW_SIZE][WINDOW_SIZE];
  logic [PROD_W-1:0] red_prod   [WINDOW_SIZE][WINDOW_SIZE];
  logic [PROD_W-1:0] green_prod [WINDOW_SIZE][WINDOW_SIZE];
  logic [PROD_W-1:0] blue_prod  [WINDOW_SIZE][WINDOW_SIZE];

  // Column entering the window: current pixel on the bottom, oldest line on top
  always_comb begin
    col_pix[0] = s1_pix_r;
    for (int k = 0; k < STORE_LINES; k++) begin
      col_pix[k + 1] = lines[k];
    end
  end

  for (genvar r = 0; r < WINDOW_SIZE; r++) begin : g_row
    for (genvar c = 0; c < WINDOW_SIZE; c++) begin : g_col
      pix_t feed;
      if (c == WINDOW_SIZE - 1) begin : g_edge
        assign feed = col_pix[WINDOW_SIZE - 1 - r];
      end else begin : g_inner
        assign feed = cell_pix[r][c + 1];
      end

      gb5_tap_cell u_cell (
        .clk      (clk),
        .shift_en (adv && s1_valid_r),
        .mult_en  (adv),
        .pix_in   (feed),
        .weight   (coeff_r[CLS_W'(tap_class(r, c))]),
        .pix_out  (cell_pix[r][c]),
        .prod     (cell_prod[r][c])
      );

      assign red_prod[r][c]   = cell_prod[r][c].red;
      assign green_prod[r][c] = cell_prod[r][c].green;
      assign blue_prod[r][c]  = cell_prod[r][c].blue;
    end
  end

  // ---------------- adder trees ----------------
  logic [TOTAL_W-1:0] red_total;
  logic [TOTAL_W-1:0] green_total;
  logic [TOTAL_W-1:0] blue_total;

  gb5_sum_tree u_sum_red (
    .clk (clk), .en (adv), .prod_in (red_prod), .total (red_total)
  );
  gb5_sum_tree u_sum_green (
    .clk (clk), .en (adv), .prod_in (green_prod), .total (green_total)
  );
  gb5_sum_tree u_sum_blue (
    .clk (clk), .en (adv), .prod_in (blue_prod), .total (blue_total)
  );

  // Carry result flags and positions alongside window, products and tree stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_pipe_r <= '0;
    end else if (adv) begin
      prod_pipe_r <= {prod_pipe_r[DEPTH-2:0], s1_prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_pipe_r[0] <= s1_pos_r;
      for (int i = 1; i < DEPTH; i++) begin
        pos_pipe_r[i] <= pos_pipe_r[i - 1];
      end
    end
  end

  // ---------------- floor, saturate and output ----------------
  function automatic logic [PIX_W-1:0] floor_sat(input logic [TOTAL_W-1:0] sum);
    logic [TOTAL_W-FRAC_W-1:0] whole;
    whole = sum[TOTAL_W-1:FRAC_W];
    return (|whole[TOTAL_W-FRAC_W-1:PIX_W]) ? {PIX_W{1'b1}} : whole[PIX_W-1:0];
  endfunction

  // Load a new result or drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && prod_pipe_r[LAST]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && prod_pipe_r[LAST]) begin
      out_data_r.red_out   <= floor_sat(red_total);
      out_data_r.green_out <= floor_sat(green_total);
      out_data_r.blue_out  <= floor_sat(blue_total);
      out_data_r.window_x  <= pos_pipe_r[LAST].x;
      out_data_r.window_y  <= pos_pipe_r[LAST].y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/gb5_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the 5x5 RGB Gaussian blur unit, bound to the top level.
// Depends on gb5_pkg for the word types.
module gb5_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input gb5_pkg::in_word_t      in_data,
  input logic                   out_valid,
  input logic                   out_stall,
  input gb5_pkg::out_word_t     out_data
);
  import gb5_pkg::*;

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  // Input stalls only behind a waiting, stalled result word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  // A stalled pixel word stays offered with the same value
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("pixel word dropped or changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

endmodule

bind gaussian_blur_5x5_rgb_unit gb5_checker u_gb5_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for gaussian_blur_5x5_rgb_unit: streams RGB words, predicts every blurred
// word with a local window model and compares field by field. Needs gb5_pkg and the block RTL.
module testbench;
  import gb5_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PRINT_CAP     = 200;

  typedef enum logic [1:0] {
    WEIGHTS_GENTLE,
    WEIGHTS_WILD,
    WEIGHTS_ZERO,
    WEIGHTS_PEAK
  } weight_mix_t;

  // one directed row: a word sent repeat_n times, with an optional hand-typed blur
  typedef struct packed {
    logic [7:0] repeat_n;
    in_word_t   word;
    logic       pinned;
    out_word_t  pin;
  } seed_row_t;

  // uniform 5x5 frame: the weights sum to just over 1.0, so every channel comes back unchanged
  localparam seed_row_t SEED_ROWS [3] = '{
    '{8'd1,  '{8'd255, 8'd0, 8'd170, 1'b1}, 1'b0, '0},
    '{8'd23, '{8'd255, 8'd0, 8'd170, 1'b0}, 1'b0, '0},
    '{8'd1,  '{8'd255, 8'd0, 8'd170, 1'b0}, 1'b1, '{8'd255, 8'd0, 8'd170, 11'd0, 11'd0}}
  };

  // weight register of a tap, by row and column distance from the center
  localparam reg_idx_t RING_REG [3][3] = '{
    '{REG_COEFF_CENTER, REG_COEFF_INNER_CROSS, REG_COEFF_OUTER_MIDDLE},
    '{REG_COEFF_INNER_CROSS, REG_COEFF_INNER_DIAGONAL, REG_COEFF_OUTER_NEAR_CORNER},
    '{REG_COEFF_OUTER_MIDDLE, REG_COEFF_OUTER_NEAR_CORNER, REG_COEFF_CORNER}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // hand-typed expectation travels alongside the word it belongs to
  logic                  pin_on = 1'b0;
  out_word_t             pin_word = '0;

  // blur predictor state
  logic [CFG_WIDTH_W-1:0] width_reg;
  logic [COEF_W-1:0]      weight_reg [NUM_REGS];
  pix_t                   line_mem [STORE_LINES][MAX_WIDTH];
  pix_t                   win [WINDOW_SIZE][WINDOW_SIZE];
  int unsigned            col_cnt = 0;
  int unsigned            row_cnt = 0;
  out_word_t              pending_blurs [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cnt = 0;
  int unsigned stall_draw;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  bit          made;
  out_word_t   blurred;

  gaussian_blur_5x5_rgb_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // start from the register reset values and an empty window
  initial begin
    width_reg = WIDTH_RESET;
    weight_reg[REG_IMAGE_WIDTH] = '0;
    for (int k = 0; k < NUM_COEFF; k++) weight_reg[k + 1] = COEFF_RESET[k];
    for (int r = 0; r < WINDOW_SIZE; r++)
      for (int c = 0; c < WINDOW_SIZE; c++) win[r][c] = '0;
  end

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
  endtask

  function automatic logic [PIX_W-1:0] clip_channel(logic [31:0] acc);
    return (acc[31:FRAC_W] > 255) ? 8'hFF : acc[FRAC_W+7:FRAC_W];
  endfunction

  // weighted sum over the current window, all three channels in the same pass
  function automatic out_word_t blur_window(int unsigned wx, int unsigned wy);
    logic [31:0]       acc_r;
    logic [31:0]       acc_g;
    logic [31:0]       acc_b;
    logic [COEF_W-1:0] wt;
    int unsigned       r;
    int unsigned       c;
    int unsigned       dr;
    int unsigned       dc;
    out_word_t         res;
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (r = 0; r < WINDOW_SIZE; r++) begin
      for (c = 0; c < WINDOW_SIZE; c++) begin
        dr = (r > CENTER_TAP) ? r - CENTER_TAP : CENTER_TAP - r;
        dc = (c > CENTER_TAP) ? c - CENTER_TAP : CENTER_TAP - c;
        wt = weight_reg[RING_REG[dr][dc]];
        acc_r += win[r][c].red * wt;
        acc_g += win[r][c].green * wt;
        acc_b += win[r][c].blue * wt;
      end
    end
    res.red_out   = clip_channel(acc_r);
    res.green_out = clip_channel(acc_g);
    res.blue_out  = clip_channel(acc_b);
    res.window_x  = POS_W'(wx);
    res.window_y  = POS_W'(wy);
    return res;
  endfunction

  // advance the line stores and window by one word; give a blur once the window is covered
  task automatic predict_blur(input in_word_t word, output bit produced, output out_word_t res);
    pix_t        column [WINDOW_SIZE];
    int unsigned span;
    int unsigned col;
    int unsigned k;
    int unsigned r;
    int unsigned c;
    span = width_reg;
    if (span < WINDOW_SIZE) span = WINDOW_SIZE;
    if (span > MAX_WIDTH) span = MAX_WIDTH;
    if (word.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= span) col_cnt = 0;
    col = col_cnt;
    column[0] = '{word.red_in, word.green_in, word.blue_in};
    for (k = 0; k < STORE_LINES; k++) column[k + 1] = line_mem[k][col];
    for (k = 0; k < STORE_LINES; k++) line_mem[k][col] = column[k];
    for (r = 0; r < WINDOW_SIZE; r++) begin
      for (c = 0; c + 1 < WINDOW_SIZE; c++) win[r][c] = win[r][c + 1];
      win[r][WINDOW_SIZE - 1] = column[WINDOW_SIZE - 1 - r];
    end
    produced = (col >= WINDOW_SIZE - 1) && (row_cnt >= WINDOW_SIZE - 1);
    res = '0;
    if (produced) res = blur_window(col - (WINDOW_SIZE - 1), row_cnt - (WINDOW_SIZE - 1));
    if (col + 1 >= span) begin
      col_cnt = 0;
      if (row_cnt < MAX_HEIGHT - 1) row_cnt++;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  task automatic check_blur(out_word_t got);
    out_word_t want;
    if (pending_blurs.size() == 0) begin
      report_mismatch("unexpected word, window_x", got.window_x, 0);
    end else begin
      want = pending_blurs.pop_front();
      if (got.red_out !== want.red_out) report_mismatch("red_out", got.red_out, want.red_out);
      if (got.green_out !== want.green_out)
        report_mismatch("green_out", got.green_out, want.green_out);
      if (got.blue_out !== want.blue_out)
        report_mismatch("blue_out", got.blue_out, want.blue_out);
      if (got.window_x !== want.window_x)
        report_mismatch("window_x", got.window_x, want.window_x);
      if (got.window_y !== want.window_y)
        report_mismatch("window_y", got.window_y, want.window_y);
    end
  endtask

  // sample both channels and the register port at each edge; watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[CFG_ADDR_W-1:2] == REG_IMAGE_WIDTH) width_reg = pwdata[CFG_WIDTH_W-1:0];
        else weight_reg[paddr[CFG_ADDR_W-1:2]] = pwdata[COEF_W-1:0];
      end
      if (in_valid && !in_stall) begin
        predict_blur(in_data, made, blurred);
        if (pin_on) pending_blurs.push_back(pin_word);
        else if (made) pending_blurs.push_back(blurred);
      end
      if (out_valid && !out_stall) check_blur(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // hold the output stalled for a random count after each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall_draw = out_calm ? 0 : $urandom_range(0, 8);
      hold_cnt <= stall_draw;
      out_stall <= (stall_draw != 0);
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end
  end

  // leave psel high between writes; the caller closes the port
  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] draw_weight(weight_mix_t mix);
    case (mix)
      WEIGHTS_ZERO:   return '0;
      WEIGHTS_PEAK:   return '1;
      WEIGHTS_GENTLE: return COEF_W'($urandom_range(0, 5200));
      default:        return COEF_W'($urandom);
    endcase
  endfunction

  // write the line width and, unless told otherwise, all six weights; junk in the upper bits
  task automatic load_setup(logic [CFG_WIDTH_W-1:0] width, weight_mix_t mix, bit width_only);
    cfg_write(REG_IMAGE_WIDTH, {20'($urandom), width});
    if (!width_only)
      for (int k = REG_COEFF_CORNER; k <= REG_COEFF_CENTER; k++)
        cfg_write(reg_idx_t'(k), {16'($urandom), draw_weight(mix)});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // offer one word after a random gap and hold it until accepted
  task automatic send_pixel(in_word_t word, logic pinned, out_word_t pin);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    pin_on <= pinned;
    pin_word <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pixel_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // random frames of random length, so restarts also land mid-line; or one long frame
  task automatic stream_frames(int unsigned n_items, int unsigned span, bit one_frame);
    in_word_t    word;
    int unsigned left_in_frame;
    int unsigned k;
    left_in_frame = 0;
    for (k = 0; k < n_items; k++) begin
      word.frame_start = 1'b0;
      if (one_frame) begin
        word.frame_start = (k == 0);
      end else if (left_in_frame == 0) begin
        word.frame_start = 1'b1;
        left_in_frame = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span * 5)
                                                    : $urandom_range(span * 5, span * 9);
      end
      word.red_in   = pixel_level();
      word.green_in = pixel_level();
      word.blue_in  = pixel_level();
      send_pixel(word, 1'b0, '0);
      if (left_in_frame != 0) left_in_frame--;
    end
  endtask

  // drop valid, wait for every pending blur, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_blurs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned span;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one 5x5 frame with reset weights, then random frames of width five
    load_setup(12'd5, WEIGHTS_GENTLE, 1'b1);
    foreach (SEED_ROWS[i])
      repeat (SEED_ROWS[i].repeat_n)
        send_pixel(SEED_ROWS[i].word, SEED_ROWS[i].pinned, SEED_ROWS[i].pin);
    stream_frames(150, 5, 1'b0);
    settle();

    // width below the window acts as five; full and zero weights
    load_setup(12'd3, WEIGHTS_PEAK, 1'b0);
    stream_frames(100, 5, 1'b0);
    settle();
    load_setup(12'd0, WEIGHTS_ZERO, 1'b0);
    stream_frames(100, 5, 1'b0);
    settle();

    // narrow random widths with moderate and arbitrary weights
    for (int k = 0; k < 4; k++) begin
      span = $urandom_range(6, 40);
      load_setup(CFG_WIDTH_W'(span), (k < 2) ? WEIGHTS_GENTLE : WEIGHTS_WILD, 1'b0);
      stream_frames(150, span, 1'b0);
      settle();
    end

    // width above the maximum acts as the maximum: the first line gives no word
    load_setup(12'd4095, WEIGHTS_GENTLE, 1'b0);
    stream_frames(64, MAX_WIDTH, 1'b1);
    settle();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
